/* rtl/core/drf_pkg.sv */
// package for the des round function unit: field widths, permutation tables and s-boxes
package drf_pkg;

	localparam int unsigned HALF_W = 32;
	localparam int unsigned KEY_W  = 48;
	localparam int unsigned IN_W   = HALF_W + KEY_W;

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_W-1:0]  key_t;

	// expansion table, des bit numbers (1 = msb)
	localparam logic [5:0] EXP_TAB [0:47] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	// output permutation table, des bit numbers (1 = msb)
	localparam logic [5:0] PERM_TAB [0:31] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	// s-boxes, indexed by row * 16 + column
	localparam logic [3:0] SBOX_TAB [0:7][0:63] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
	};

	// e expansion: 32 bits to 48, msb first
	function automatic key_t expand(input half_t r);
		key_t       x;
		logic [5:0] pos;
		x = '0;
		for (int i = 0; i < 48; i++) begin
			pos = 6'd32 - EXP_TAB[i];
			x[47 - i] = r[pos[4:0]];
		end
		return x;
	endfunction

	// eight s-box lookups, group 0 from the top six bits
	function automatic half_t substitute(input key_t x);
		half_t      s;
		logic [5:0] g;
		for (int i = 0; i < 8; i++) begin
			g = x[42 - 6*i +: 6];
			s[28 - 4*i +: 4] = SBOX_TAB[i][{g[5], g[0], g[4:1]}];
		end
		return s;
	endfunction

	// p permutation, msb first
	function automatic half_t permute(input half_t s);
		half_t      p;
		logic [5:0] pos;
		for (int i = 0; i < 32; i++) begin
			pos = 6'd32 - PERM_TAB[i];
			p[31 - i] = s[pos[4:0]];
		end
		return p;
	endfunction

endpackage

/* rtl/core/des_round_function_unit.sv */
// des feistel round function f: input register, expansion/s-box/permutation, result register
//
//  channel | dir | handshake          | tdata (lsb first)
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | right_half [31:0], round_key [79:32]
//  m_*     | out | m_tvalid/m_tready  | f_result [31:0]
//
// one item per cycle unless m_tready stalls; m_tvalid rises once the item moves to stage 2
// the expansion, s-box and p logic between the input and result registers sets the path
// arst_n clears both stage valids; data registers keep no reset
// a stalled result holds in the output register while one more item may wait in the input stage
// s_tready drops only when both stages are full and m_tready is low
module des_round_function_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // right_half [31:0], round_key [79:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // f_result [31:0]
);

	logic            valid_s1;
	drf_pkg::half_t  right_half_s1;
	drf_pkg::key_t   round_key_s1;
	logic            valid_s2;
	drf_pkg::half_t  f_result_s2;
	logic            advance;
	drf_pkg::half_t  f_comb;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// round function on the registered item
	assign f_comb = drf_pkg::permute(drf_pkg::substitute(
		drf_pkg::expand(right_half_s1) ^ round_key_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			right_half_s1 <= s_tdata[31:0];
			round_key_s1  <= s_tdata[79:32];
		end
		if (advance && valid_s1) begin
			f_result_s2 <= f_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = f_result_s2;

	// an empty input stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	// a moving item shows up as a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("item lost between stages");

	// a blocked item keeps its operands
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(right_half_s1)
			&& $stable(round_key_s1)))
		else $error("input stage changed while blocked");

	// the result register takes the round function of the item that moved
	a_result_value: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (m_tdata == $past(f_comb)))
		else $error("result register mismatch");

endmodule

/* bench/tb.sv */
// testbench for des_round_function_unit: streamed items, f-function predictor, result checks
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// standard des p table, des bit numbers (1 = msb)
	localparam int P_SEL [0:31] = '{
		16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
		2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
	};

	// s-box rows, index box * 4 + row; column 0 sits in the top nibble
	localparam logic [63:0] SBOX_ROWS [0:31] = '{
		64'he4d12fb83a6c5907, 64'h0f74e2d1a6cb9538, 64'h41e8d62bfc973a50, 64'hfc8249175b3ea06d,
		64'hf18e6b34972dc05a, 64'h3d47f28ec01a69b5, 64'h0e7ba4d158c6932f, 64'hd8a13f42b67c05e9,
		64'ha09e63f51dc7b428, 64'hd709346a285ecbf1, 64'hd6498f30b12c5ae7, 64'h1ad069874fe3b52c,
		64'h7de3069a1285bc4f, 64'hd8b56f03472c1ae9, 64'ha690cb7df13e5284, 64'h3f06a1d8945bc72e,
		64'h2c417ab6853fd0e9, 64'heb2c47d150fa3986, 64'h421bad78f9c5630e, 64'hb8c71e2d6f09a453,
		64'hc1af92680d34e75b, 64'haf427c9561de0b38, 64'h9ef528c3704a1db6, 64'h432c95fabe17608d,
		64'h4b2ef08d3c975a61, 64'hd0b7491ae35c2f86, 64'h14bdc37eaf680592, 64'h6bd814a7950fe23c,
		64'hd2846fb1a93e50c7, 64'h1fd8a374c56b0e92, 64'h7b419ce206adf358, 64'h21e74a8dfc90356b
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [drf_pkg::IN_W-1:0] s_tdata = '0;   // right_half [31:0], round_key [79:32]
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [31:0]              m_tdata;        // f_result [31:0]

	drf_pkg::half_t f_expected [$];
	int             err_count = 0;
	int             cycle_count = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;

	des_round_function_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// f(r, k) = p(s(e(r) ^ k)), des bit 1 is the msb of each word
	function automatic drf_pkg::half_t des_f(input drf_pkg::half_t r, input drf_pkg::key_t k);
		logic [33:0]    ring;
		logic [5:0]     grp;
		drf_pkg::half_t sub;
		drf_pkg::half_t res;
		logic [1:0]     row;
		logic [3:0]     col;
		// des bit n lands at ring[33 - n]; bit 0 wraps to 32 and bit 33 to 1
		ring = {r[0], r, r[31]};
		for (int i = 0; i < 8; i++) begin
			grp = ring[33 - 4*i -: 6] ^ k[47 - 6*i -: 6];
			row = {grp[5], grp[0]};
			col = grp[4:1];
			sub[31 - 4*i -: 4] = SBOX_ROWS[4*i + row][63 - 4*col -: 4];
		end
		for (int i = 0; i < 32; i++)
			res[31 - i] = sub[32 - P_SEL[i]];
		return res;
	endfunction

	// mostly uniform values, with all-zero, all-one, one-hot and one-cold words mixed in
	function automatic drf_pkg::half_t rand_half();
		int mode;
		mode = $urandom_range(9);
		case (mode)
			0: return '0;
			1: return '1;
			2: return drf_pkg::half_t'(1) << $urandom_range(31);
			3: return ~(drf_pkg::half_t'(1) << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	function automatic drf_pkg::key_t rand_key();
		int mode;
		mode = $urandom_range(9);
		case (mode)
			0: return '0;
			1: return '1;
			2: return drf_pkg::key_t'(1) << $urandom_range(47);
			3: return ~(drf_pkg::key_t'(1) << $urandom_range(47));
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	// entered and left in the time step of a rising edge; valid stays up for a follow-on item
	task automatic send_item(input drf_pkg::half_t r, input drf_pkg::key_t k);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {k, r};
		// ready is sampled mid-cycle, where it is settled for the coming edge
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		f_expected.push_back(des_f(r, k));
	endtask

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++)
			send_item(rand_half(), rand_key());
	endtask

	// field extremes, wrap-around bits of the expansion and s-box corner entries
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(32'h00000000, 48'h000000000000);
		send_item(32'hffffffff, 48'h000000000000);
		send_item(32'h00000000, 48'hffffffffffff);
		send_item(32'hffffffff, 48'hffffffffffff);
		send_item(32'h55555555, 48'haaaaaaaaaaaa);
		send_item(32'haaaaaaaa, 48'h555555555555);
		// des bit 1 feeds group 0 and group 7
		send_item(32'h80000000, 48'h000000000000);
		// des bit 32 feeds group 7 and group 0
		send_item(32'h00000001, 48'h000000000000);
		// every group at row 3 column 0, row 0 column 15, row 2 column 15, row 1 column 0
		send_item(32'h00000000, 48'h861861861861);
		send_item(32'h00000000, 48'h79e79e79e79e);
		send_item(32'h00000000, 48'hfbefbefbefbe);
		send_item(32'h00000000, 48'h041041041041);
		send_item(32'hf0aaf0aa, 48'h1b02effc7072);
		send_item(32'h12345678, 48'h0123456789ab);
		send_item(32'hfedcba98, 48'hfedcba987654);
	endtask

	task automatic test_no_idle();
		run_random(260, 0, 0);
	endtask

	task automatic test_sender_idle();
		run_random(240, 75, 0);
	endtask

	task automatic test_receiver_stall();
		run_random(240, 0, 75);
	endtask

	task automatic test_both_idle();
		run_random(215, 15, 15);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// results are checked mid-cycle, the handshake completes at the next edge
	always @(negedge clk) begin
		drf_pkg::half_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (f_expected.size() == 0) begin
				$error("f_result: unexpected item, actual %08h", m_tdata);
				err_count++;
			end else begin
				want = f_expected.pop_front();
				if (m_tdata !== want) begin
					$error("f_result: expected %08h, actual %08h", want, m_tdata);
					err_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		s_tvalid <= 1'b0;
		while (f_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
